// ----- design/sfdl_pkg.sv -----
package sfdl_pkg;

  // defaults for the top level parameters
  localparam int STORE_DEPTH_DEF   = 131072;
  localparam int SAMPLE_WIDTH_DEF  = 24;
  localparam int FRACTION_BITS_DEF = 12;

  // fixed field and register widths
  localparam int SETTING_W  = 24;
  localparam int SPMS_W     = 24;
  localparam int SPB_W      = 28;
  localparam int MAXD_W     = 17;
  localparam int CFG_DATA_W = 28;
  localparam int CFG_IDX_W  = 3;

  // scaling of the delay setting
  localparam int MS_SHIFT         = 16;
  localparam int BEAT_SHIFT       = 8;
  localparam int BEAT_LIMIT_BEATS = 4;

  // register reset values
  localparam logic              TEMPO_SYNC_RST = 1'b0;
  localparam logic [SPMS_W-1:0] SPMS_RST       = 24'd2890138;
  localparam logic [SPB_W-1:0]  SPB_RST        = 28'd5644800;
  localparam logic [MAXD_W-1:0] MAXD_RST       = 17'd88200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMPO_SYNC = 3'd0,
    CFG_SPMS       = 3'd1,
    CFG_SPB        = 3'd2,
    CFG_MAXD       = 3'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_RD0,
    ST_RD1,
    ST_MUL,
    ST_SUM
  } state_t;

endpackage

// ----- design/sfdl_ifs.sv -----
interface sfdl_in_if #(
  parameter int SAMPLE_WIDTH = sfdl_pkg::SAMPLE_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [SAMPLE_WIDTH-1:0]    left_in;
  logic signed [SAMPLE_WIDTH-1:0]    right_in;
  logic [sfdl_pkg::SETTING_W-1:0]    delay_setting;

  modport source (output valid, left_in, right_in, delay_setting, input ready);
  modport sink   (input valid, left_in, right_in, delay_setting, output ready);
endinterface

interface sfdl_out_if #(
  parameter int SAMPLE_WIDTH = sfdl_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface sfdl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sfdl_pkg::CFG_IDX_W-1:0]  idx;
  logic [sfdl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// ----- design/sfdl_ram.sv -----
module sfdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/stereo_fractional_delay_line_core.sv -----
// stereo delay line with linearly interpolated fractional delay. each request carries a left
// and right sample and a delay setting with FRACTION_BITS fraction bits, read as milliseconds
// or, with tempo sync set, as beats (clamped to four beats). the setting is scaled to samples,
// saturated at max_delay_samples, and both channels return the blend of the two stored
// samples around that delay. the new pair is written before the taps are read, so a delay
// under one sample blends in the current input. the scaling multiply works on the request
// ports in the accepting cycle; the steps from there to a loaded result are, in order:
// saturate and store write, two reads of the single read port of the sample memory, the
// blend multiply, then the sum. the next request is taken when the block is back in idle, so
// no request is taken while one is still in flight; a result still waiting in the output
// register holds the sum stage and with it the input. STORE_DEPTH must be a power of two.
// the memory is not cleared after reset: a wrap marker tracks which entries have been
// written and unwritten entries read as zero, so the block is ready at once after reset.
// configuration writes are taken at any time and are meant to happen only while the block
// is idle.
module stereo_fractional_delay_line_core #(
  parameter int STORE_DEPTH   = sfdl_pkg::STORE_DEPTH_DEF,
  parameter int SAMPLE_WIDTH  = sfdl_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRACTION_BITS = sfdl_pkg::FRACTION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sfdl_in_if.sink    in_chan,
  sfdl_out_if.source out_chan,
  sfdl_cfg_if.sink   cfg_chan
);

  // widths
  localparam int AW      = $clog2(STORE_DEPTH);
  localparam int OFS_W   = (AW > sfdl_pkg::MAXD_W) ? AW : sfdl_pkg::MAXD_W;
  localparam int PROD_W  = sfdl_pkg::SETTING_W + sfdl_pkg::SPB_W;
  localparam int D_W     = PROD_W - sfdl_pkg::BEAT_SHIFT;
  localparam int LIM_W   = sfdl_pkg::MAXD_W + FRACTION_BITS;
  localparam int WGT_W   = FRACTION_BITS + 1;
  localparam int BP_W    = SAMPLE_WIDTH + WGT_W + 1;
  localparam int SUM_W   = BP_W + 1;
  localparam int PAIR_W  = 2 * SAMPLE_WIDTH;

  localparam logic [sfdl_pkg::SETTING_W-1:0] BEAT_LIMIT =
    sfdl_pkg::SETTING_W'(sfdl_pkg::BEAT_LIMIT_BEATS) << FRACTION_BITS;
  localparam logic [WGT_W-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  // configuration registers
  logic                        tempo_sync_r;
  logic [sfdl_pkg::SPMS_W-1:0] spms_r;
  logic [sfdl_pkg::SPB_W-1:0]  spb_r;
  logic [sfdl_pkg::MAXD_W-1:0] maxd_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_sync_r <= sfdl_pkg::TEMPO_SYNC_RST;
      spms_r       <= sfdl_pkg::SPMS_RST;
      spb_r        <= sfdl_pkg::SPB_RST;
      maxd_r       <= sfdl_pkg::MAXD_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.idx)
        sfdl_pkg::CFG_TEMPO_SYNC: tempo_sync_r <= cfg_chan.data[0];
        sfdl_pkg::CFG_SPMS:       spms_r       <= cfg_chan.data[sfdl_pkg::SPMS_W-1:0];
        sfdl_pkg::CFG_SPB:        spb_r        <= cfg_chan.data[sfdl_pkg::SPB_W-1:0];
        sfdl_pkg::CFG_MAXD:       maxd_r       <= cfg_chan.data[sfdl_pkg::MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  sfdl_pkg::state_t state_r, state_nxt;
  logic             in_acc;
  logic             ram_we;
  logic             load_out;

  assign in_acc = in_chan.valid & in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfdl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_chan.ready = 1'b0;
    ram_we        = 1'b0;
    load_out      = 1'b0;
    case (state_r)
      sfdl_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          state_nxt = sfdl_pkg::ST_LIMIT;
        end
      end
      sfdl_pkg::ST_LIMIT: begin
        ram_we    = 1'b1;
        state_nxt = sfdl_pkg::ST_RD0;
      end
      sfdl_pkg::ST_RD0: state_nxt = sfdl_pkg::ST_RD1;
      sfdl_pkg::ST_RD1: state_nxt = sfdl_pkg::ST_MUL;
      sfdl_pkg::ST_MUL: state_nxt = sfdl_pkg::ST_SUM;
      sfdl_pkg::ST_SUM: begin
        // hold the sum until the output register is free
        if (!out_chan.valid || out_chan.ready) begin
          load_out  = 1'b1;
          state_nxt = sfdl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sfdl_pkg::ST_IDLE;
    endcase
  end

  // scaling multiply, straight from the request ports
  logic [sfdl_pkg::SETTING_W-1:0] setting_clamped;
  logic [sfdl_pkg::SETTING_W-1:0] mul_a;
  logic [sfdl_pkg::SPB_W-1:0]     mul_b;
  logic [PROD_W-1:0]              prod_nxt;
  logic [PROD_W-1:0]              prod_r;
  logic                           beat_sel_r;
  logic signed [SAMPLE_WIDTH-1:0] left_r;
  logic signed [SAMPLE_WIDTH-1:0] right_r;

  assign setting_clamped = (in_chan.delay_setting > BEAT_LIMIT) ? BEAT_LIMIT
                                                                : in_chan.delay_setting;
  assign mul_a    = tempo_sync_r ? setting_clamped : in_chan.delay_setting;
  assign mul_b    = tempo_sync_r ? spb_r : sfdl_pkg::SPB_W'(spms_r);
  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      prod_r     <= prod_nxt;
      beat_sel_r <= tempo_sync_r;
      left_r     <= in_chan.left_in;
      right_r    <= in_chan.right_in;
    end
  end

  // delay in samples, saturated at the limit with a zero fraction
  logic [D_W-1:0]                d_val;
  logic [LIM_W-1:0]              lim;
  logic                          sat;
  logic [sfdl_pkg::MAXD_W-1:0]   n_nxt, n_r;
  logic [FRACTION_BITS-1:0]      f_nxt, f_r;

  assign d_val = beat_sel_r ? D_W'(prod_r >> sfdl_pkg::BEAT_SHIFT)
                            : D_W'(prod_r >> sfdl_pkg::MS_SHIFT);
  assign lim   = LIM_W'(maxd_r) << FRACTION_BITS;
  assign sat   = d_val > D_W'(lim);
  assign n_nxt = sat ? maxd_r : d_val[FRACTION_BITS +: sfdl_pkg::MAXD_W];
  assign f_nxt = sat ? '0 : d_val[FRACTION_BITS-1:0];

  always_ff @(posedge clk) begin
    if (state_r == sfdl_pkg::ST_LIMIT) begin
      n_r <= n_nxt;
      f_r <= f_nxt;
    end
  end

  // write pointer and wrap marker: before the first wrap only entries up to the
  // pointer hold written samples, everything else reads as zero
  logic [AW-1:0] wptr_r;
  logic          wrapped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r    <= '0;
      wrapped_r <= 1'b0;
    end else if (load_out) begin
      wptr_r <= wptr_r + AW'(1);
      if (wptr_r == AW'(STORE_DEPTH - 1)) begin
        wrapped_r <= 1'b1;
      end
    end
  end

  // sample memory, left and right side by side
  logic [OFS_W-1:0]  n_ofs;
  logic [AW-1:0]     i0_calc, i0_r, i1_calc;
  logic [AW-1:0]     raddr;
  logic [PAIR_W-1:0] rdata;
  logic              valid0_r, valid1_r;

  assign n_ofs   = OFS_W'(n_r);
  assign i0_calc = wptr_r - n_ofs[AW-1:0];
  assign i1_calc = i0_r - AW'(1);
  assign raddr   = (state_r == sfdl_pkg::ST_RD0) ? i0_calc : i1_calc;

  sfdl_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata ({left_r, right_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (state_r == sfdl_pkg::ST_RD0) begin
      i0_r     <= i0_calc;
      valid0_r <= wrapped_r || (i0_calc <= wptr_r);
    end
    if (state_r == sfdl_pkg::ST_RD1) begin
      valid1_r <= wrapped_r || (i1_calc <= wptr_r);
    end
  end

  // interpolation
  logic signed [SAMPLE_WIDTH-1:0] a_l_r, a_r_r;
  logic signed [SAMPLE_WIDTH-1:0] b_l, b_r;
  logic [WGT_W-1:0]               wgt0;
  logic signed [WGT_W:0]          wgt0_s, wgt1_s;
  logic signed [BP_W-1:0]         pl0_r, pl1_r, pr0_r, pr1_r;
  logic signed [SUM_W-1:0]        sum_l, sum_r;
  logic signed [SUM_W-1:0]        sh_l, sh_r;

  assign wgt0   = FRAC_ONE - WGT_W'(f_r);
  assign wgt0_s = signed'({1'b0, wgt0});
  assign wgt1_s = signed'({2'b00, f_r});
  assign b_l    = valid1_r ? signed'(rdata[PAIR_W-1:SAMPLE_WIDTH]) : '0;
  assign b_r    = valid1_r ? signed'(rdata[SAMPLE_WIDTH-1:0]) : '0;

  always_ff @(posedge clk) begin
    if (state_r == sfdl_pkg::ST_RD1) begin
      a_l_r <= valid0_r ? signed'(rdata[PAIR_W-1:SAMPLE_WIDTH]) : '0;
      a_r_r <= valid0_r ? signed'(rdata[SAMPLE_WIDTH-1:0]) : '0;
    end
    if (state_r == sfdl_pkg::ST_MUL) begin
      pl0_r <= a_l_r * wgt0_s;
      pl1_r <= b_l * wgt1_s;
      pr0_r <= a_r_r * wgt0_s;
      pr1_r <= b_r * wgt1_s;
    end
  end

  // arithmetic shift floors the weighted sum
  assign sum_l = SUM_W'(pl0_r) + SUM_W'(pl1_r);
  assign sum_r = SUM_W'(pr0_r) + SUM_W'(pr1_r);
  assign sh_l  = sum_l >>> FRACTION_BITS;
  assign sh_r  = sum_r >>> FRACTION_BITS;

  // output register
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] left_out_r, right_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      left_out_r  <= sh_l[SAMPLE_WIDTH-1:0];
      right_out_r <= sh_r[SAMPLE_WIDTH-1:0];
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.left_out  = left_out_r;
  assign out_chan.right_out = right_out_r;

  // checks
  a_ptr_moves_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (wptr_r != $past(wptr_r)) |-> $past(load_out))
    else $error("write pointer moved without a result");

  a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(wrapped_r))
    else $error("wrap marker dropped");

  a_delay_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sfdl_pkg::ST_RD0) |-> (n_r <= maxd_r))
    else $error("delay above limit");

  a_sat_no_frac: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sfdl_pkg::ST_RD0 && n_r == maxd_r) |-> (f_r == '0))
    else $error("saturated delay kept a fraction");

  a_load_frees: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_valid_r && state_r == sfdl_pkg::ST_IDLE))
    else $error("result not presented after load");

endmodule

// ----- tb/stereo_fractional_delay_line_core_test.sv -----
`timescale 1ns / 1ps

module stereo_fractional_delay_line_core_test;
  import sfdl_pkg::*;

  // block geometry, taken from the package defaults the core is built with
  localparam int DEPTH  = STORE_DEPTH_DEF;
  localparam int ADDR_W = $clog2(STORE_DEPTH_DEF);
  localparam int SW     = SAMPLE_WIDTH_DEF;
  localparam int FB     = FRACTION_BITS_DEF;

  localparam longint FRAC_ONE = longint'(1) << FB;
  localparam int     ONE_UNIT = 1 << FB;  // one ms, or one beat
  localparam logic [63:0] BEAT_CAP = 64'(BEAT_LIMIT_BEATS) << FB;

  // register values worth hitting
  localparam logic [SPMS_W-1:0] SPMS_TOP = 24'd12582912;  // 192 samples per ms
  localparam logic [SPB_W-1:0]  SPB_ALL  = '1;
  localparam logic [MAXD_W-1:0] MAXD_ALL = '1;

  localparam int RESET_CYCLES  = 3;
  localparam int SETTLE_CYCLES = 8;    // margin for the core to fall idle after the last result
  localparam int HOLD_CYCLES   = 200;
  localparam int REPORT_LIMIT  = 10;
  localparam int TIMEOUT_NS    = 2_000_000;

  typedef logic signed [SW-1:0] sample_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct {
    sample_t left;
    sample_t right;
  } frame_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  // how the result side takes results
  typedef enum {SINK_FREE, SINK_PATTERN, SINK_RANDOM} sink_mode_t;

  logic clk;
  logic rst_n;

  sfdl_in_if  in_chan ();
  sfdl_out_if out_chan ();
  sfdl_cfg_if cfg_chan ();

  stereo_fractional_delay_line_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // shadow copy of the delay line: both sample stores, write pointer, registers
  sample_t              left_mem  [DEPTH];
  sample_t              right_mem [DEPTH];
  addr_t                wr_ptr;
  logic                 beat_mode;
  logic [SPMS_W-1:0]    spms;
  logic [SPB_W-1:0]     spb;
  logic [MAXD_W-1:0]    maxd;

  frame_t     pending_frames[$];   // delayed pairs still owed by the block
  int         frame_errors;
  sink_mode_t sink_mode = SINK_FREE;
  bit         hold_request;        // asks the result side for one long hold-off

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // linear blend between two taps, the shift floors towards minus infinity
  function automatic sample_t interp(sample_t near_tap, sample_t far_tap, logic [FB-1:0] frac);
    longint acc;
    acc = longint'(near_tap) * (FRAC_ONE - longint'(frac)) + longint'(far_tap) * longint'(frac);
    return sample_t'(acc >>> FB);
  endfunction

  // one request through the shadow delay line: scale, saturate, write, read two taps
  function automatic frame_t delay_line_predict(sample_t l, sample_t r,
                                                logic [SETTING_W-1:0] setting);
    logic [63:0]   amount;
    logic [63:0]   scaled;
    logic [63:0]   ceiling;
    logic [FB-1:0] frac;
    addr_t         tap0;
    addr_t         tap1;
    frame_t        res;
    amount = 64'(setting);
    if (beat_mode) begin
      // beats are clamped to four before scaling
      if (amount > BEAT_CAP) amount = BEAT_CAP;
      scaled = (amount * 64'(spb)) >> BEAT_SHIFT;
    end else begin
      scaled = (amount * 64'(spms)) >> MS_SHIFT;
    end
    // saturation leaves a whole number of samples, fraction zero
    ceiling = 64'(maxd) << FB;
    if (scaled > ceiling) scaled = ceiling;
    frac = scaled[FB-1:0];
    // new pair goes in first, so a delay under one sample blends the current input
    left_mem[wr_ptr]  = l;
    right_mem[wr_ptr] = r;
    tap0 = wr_ptr - addr_t'(scaled >> FB);
    tap1 = tap0 - addr_t'(1);
    res.left  = interp(left_mem[tap0], left_mem[tap1], frac);
    res.right = interp(right_mem[tap0], right_mem[tap1], frac);
    wr_ptr = wr_ptr + addr_t'(1);
    return res;
  endfunction

  // register bits above each width are dropped, unused indexes do nothing
  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_TEMPO_SYNC: beat_mode = data[0];
      CFG_SPMS:       spms      = data[SPMS_W-1:0];
      CFG_SPB:        spb       = data[SPB_W-1:0];
      CFG_MAXD:       maxd      = data[MAXD_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // offer one request and hold it until the block takes it; valid stays high
  task automatic send_frame(sample_t l, sample_t r, logic [SETTING_W-1:0] setting);
    in_chan.valid         <= 1'b1;
    in_chan.left_in       <= l;
    in_chan.right_in      <= r;
    in_chan.delay_setting <= setting;
    do @(posedge clk); while (!in_chan.ready);
    pending_frames.push_back(delay_line_predict(l, r, setting));
  endtask

  // stop offering, let every owed result come out, then let the core fall idle
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes only ever happen with the block idle
  task automatic write_regs(reg_write_t writes[$]);
    drain();
    foreach (writes[k]) begin
      cfg_chan.valid <= 1'b1;
      cfg_chan.idx   <= writes[k].idx;
      cfg_chan.data  <= writes[k].data;
      do @(posedge clk); while (!cfg_chan.ready);
      shadow_write(writes[k].idx, writes[k].data);
    end
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic load_config(logic bs, logic [SPMS_W-1:0] spms_val,
                             logic [SPB_W-1:0] spb_val, logic [MAXD_W-1:0] maxd_val);
    reg_write_t writes[$];
    writes.push_back('{CFG_TEMPO_SYNC, CFG_DATA_W'(bs)});
    writes.push_back('{CFG_SPMS, CFG_DATA_W'(spms_val)});
    writes.push_back('{CFG_SPB, CFG_DATA_W'(spb_val)});
    writes.push_back('{CFG_MAXD, CFG_DATA_W'(maxd_val)});
    write_regs(writes);
  endtask

  // random requests in bursts; settings lean towards delays that land inside the history
  task automatic run_random(int count, int unsigned max_setting, bit idle_on);
    int                   burst_left;
    logic [SETTING_W-1:0] setting;
    burst_left = $urandom_range(1, 24);
    repeat (count) begin
      case ($urandom_range(0, 9))
        0:       setting = '0;
        1:       setting = '1;
        2, 3:    setting = SETTING_W'($urandom);
        default: setting = SETTING_W'($urandom_range(0, max_setting));
      endcase
      send_frame(pick_sample(), pick_sample(), setting);
      burst_left--;
      if (burst_left == 0) begin
        // every so often a long burst with no gap at all
        burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 24);
        if (idle_on) begin
          in_chan.valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end
  endtask

  // corner cases, starting from the reset registers
  task automatic test_directed_edges();
    sink_mode = SINK_FREE;
    // zero delay returns the input itself, at both sample extremes
    send_frame(SAMPLE_MAX, SAMPLE_MIN, '0);
    send_frame(SAMPLE_MIN, SAMPLE_MAX, '0);
    // fraction of a sample: blends current input with the previous one, floor on negatives
    send_frame(SAMPLE_MIN, sample_t'(-3), SETTING_W'(1));
    send_frame(sample_t'(-1), sample_t'(1), SETTING_W'(1));
    // one ms back lands on entries never written, which read as zero
    send_frame(sample_t'(1000), sample_t'(-1000), SETTING_W'(ONE_UNIT));
    // full scale setting saturates at the maximum delay
    send_frame(SAMPLE_MAX, SAMPLE_MAX, '1);

    // beat mode with the widest limit
    load_config(1'b1, SPMS_RST, SPB_RST, MAXD_ALL);
    send_frame(pick_sample(), pick_sample(), '1);
    send_frame(pick_sample(), pick_sample(), SETTING_W'(BEAT_CAP));
    send_frame(pick_sample(), pick_sample(), SETTING_W'(BEAT_CAP + 1));
    send_frame(sample_t'(-7), sample_t'(7), SETTING_W'(1));
    send_frame(SAMPLE_MIN, SAMPLE_MIN, '0);

    // largest beat scale: fraction of all ones
    load_config(1'b1, SPMS_RST, SPB_ALL, MAXD_ALL);
    send_frame(SAMPLE_MIN, SAMPLE_MAX, SETTING_W'(1));
    send_frame(SAMPLE_MAX, SAMPLE_MIN, SETTING_W'(2));

    // fastest ms scale: delay saturates one short of the store and wraps round
    load_config(1'b0, SPMS_TOP, SPB_RST, MAXD_ALL);
    send_frame(SAMPLE_MAX, sample_t'(-5), '1);
    send_frame(sample_t'(-5), SAMPLE_MAX, SETTING_W'(1));

    // zero scale and zero limit both force a delay of nothing
    load_config(1'b0, '0, SPB_RST, MAXD_ALL);
    send_frame(pick_sample(), pick_sample(), '1);
    load_config(1'b0, SPMS_TOP, SPB_RST, '0);
    send_frame(pick_sample(), pick_sample(), '1);
    send_frame(pick_sample(), pick_sample(), SETTING_W'(1));
  endtask

  task automatic test_ms_scaling();
    sink_mode = SINK_PATTERN;
    load_config(1'b0, SPMS_RST, SPB_RST, MAXD_RST);
    run_random(300, 30 * ONE_UNIT, 1'b1);
    sink_mode = SINK_RANDOM;
    load_config(1'b0, SPMS_TOP, SPB_RST, MAXD_ALL);
    run_random(250, 8 * ONE_UNIT, 1'b1);
  endtask

  task automatic test_beat_scaling();
    // 100 samples per beat, so the four beat clamp stays inside the history
    sink_mode = SINK_RANDOM;
    load_config(1'b1, SPMS_RST, 28'd25600, MAXD_ALL);
    run_random(300, 6 * ONE_UNIT, 1'b1);
    sink_mode = SINK_FREE;
    load_config(1'b1, SPMS_RST, SPB_ALL, MAXD_ALL);
    run_random(200, 6, 1'b0);
  endtask

  task automatic test_saturation();
    // small limits so that saturated taps still read real history
    sink_mode = SINK_PATTERN;
    load_config(1'b0, SPMS_RST, SPB_RST, MAXD_W'($urandom_range(1, 600)));
    run_random(250, 32'hFFFFFF, 1'b1);
    load_config(1'b1, SPMS_RST, SPB_RST, '0);
    run_random(50, 32'hFFFFFF, 1'b1);
  endtask

  task automatic test_register_noise();
    reg_write_t writes[$];
    // junk above each narrower register's width, then writes to the unused indexes
    writes.push_back('{CFG_TEMPO_SYNC, 28'hFFFFFFE});
    writes.push_back('{CFG_SPMS, {4'hF, SPMS_RST}});
    writes.push_back('{CFG_SPB, SPB_RST});
    writes.push_back('{CFG_MAXD, {11'h7FF, 17'd900}});
    for (int k = CFG_MAXD + 1; k < 2 ** CFG_IDX_W; k++)
      writes.push_back('{CFG_IDX_W'(k), CFG_DATA_W'($urandom)});
    write_regs(writes);
    sink_mode = SINK_RANDOM;
    run_random(100, 30 * ONE_UNIT, 1'b1);
  endtask

  // result side holds off for a long stretch while requests keep coming, so the core fills
  task automatic test_backpressure();
    load_config(1'b0, SPMS_RST, SPB_RST, 17'd600);
    sink_mode = SINK_PATTERN;
    repeat (2) begin
      hold_request = 1'b1;
      run_random(40, 20 * ONE_UNIT, 1'b0);
    end
  endtask

  task automatic test_config_sweep();
    logic [SPMS_W-1:0] spms_val;
    logic [SPB_W-1:0]  spb_val;
    logic [MAXD_W-1:0] maxd_val;
    repeat (6) begin
      case ($urandom_range(0, 3))
        0:       spms_val = '0;
        1:       spms_val = SPMS_TOP;
        2:       spms_val = SPMS_W'($urandom);
        default: spms_val = SPMS_W'($urandom_range(0, SPMS_TOP));
      endcase
      case ($urandom_range(0, 2))
        0:       spb_val = SPB_ALL;
        1:       spb_val = SPB_W'($urandom);
        default: spb_val = SPB_W'($urandom_range(0, 1 << 18));
      endcase
      case ($urandom_range(0, 3))
        0:       maxd_val = '0;
        1:       maxd_val = MAXD_ALL;
        2:       maxd_val = MAXD_W'($urandom);
        default: maxd_val = MAXD_W'($urandom_range(1, 1500));
      endcase
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      load_config(1'($urandom_range(0, 1)), spms_val, spb_val, maxd_val);
      run_random(80, 2 * ONE_UNIT, 1'($urandom_range(0, 1)));
    end
  endtask

  // result side: a long hold-off when asked, else free running, a rotating stall pattern, or random stalls
  initial begin
    int          hold_left;
    logic [15:0] stall_mask;
    hold_left  = 0;
    stall_mask = 16'b1101_1110_1111_0111;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_PATTERN: begin
            out_chan.ready <= stall_mask[0];
            stall_mask = {stall_mask[0], stall_mask[15:1]};
          end
          SINK_RANDOM: out_chan.ready <= ($urandom_range(0, 3) != 0);
          default:     out_chan.ready <= 1'b1;
        endcase
      end
    end
  end

  // every result taken is matched against the oldest owed pair
  always @(posedge clk) begin
    frame_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_frames.size() == 0) begin
        frame_errors++;
        if (frame_errors <= REPORT_LIMIT)
          $display("unexpected result: left %0d right %0d",
                   out_chan.left_out, out_chan.right_out);
      end else begin
        want = pending_frames.pop_front();
        if (want.left !== out_chan.left_out || want.right !== out_chan.right_out) begin
          frame_errors++;
          if (frame_errors <= REPORT_LIMIT)
            $display("result mismatch: left exp %0d got %0d, right exp %0d got %0d",
                     want.left, out_chan.left_out, want.right, out_chan.right_out);
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.left_in       <= '0;
    in_chan.right_in      <= '0;
    in_chan.delay_setting <= '0;
    cfg_chan.valid        <= 1'b0;
    cfg_chan.idx          <= '0;
    cfg_chan.data         <= '0;
    // shadow state after reset: empty stores, pointer at zero, default registers
    foreach (left_mem[k]) begin
      left_mem[k]  = '0;
      right_mem[k] = '0;
    end
    wr_ptr       = '0;
    beat_mode    = TEMPO_SYNC_RST;
    spms         = SPMS_RST;
    spb          = SPB_RST;
    maxd         = MAXD_RST;
    frame_errors = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_ms_scaling();
    test_beat_scaling();
    test_saturation();
    test_register_noise();
    test_backpressure();
    test_config_sweep();

    // wait out every owed result, then a few more cycles for anything stray
    drain();
    if (frame_errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
